// ===== sv/cfpf_pkg.sv =====
// Shared types, register indexes and the coordinate scaling function
// for the contour feature point finder. No dependencies.
package cfpf_pkg;

    // Grid edge length; a power of two, so scaling divides by a shift
    localparam int GRID_SIZE  = 256;
    localparam int GRID_SHIFT = $clog2(GRID_SIZE);

    localparam int COORD_W = 8;
    localparam int SIZE_W  = 14;
    localparam int ADDR_W  = 3;
    localparam int PROD_W  = COORD_W + SIZE_W;

    localparam logic [SIZE_W-1:0] OUT_MAX = SIZE_W'(16383);

    typedef enum logic [ADDR_W-1:0] {
        REG_ANGLE_CX = 3'd0,
        REG_ANGLE_CY = 3'd1,
        REG_VERT_CX  = 3'd2,
        REG_VERT_CY  = 3'd3,
        REG_WIDTH    = 3'd4,
        REG_HEIGHT   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] angle_cx;
        logic [COORD_W-1:0] angle_cy;
        logic [COORD_W-1:0] vert_cx;
        logic [COORD_W-1:0] vert_cy;
        logic [SIZE_W-1:0]  width;
        logic [SIZE_W-1:0]  height;
    } t_cfg;

    typedef struct packed {
        t_point left;
        t_point right;
        t_point top;
        t_point bottom;
        logic   top_found;
        logic   bottom_found;
    } t_snap;

    typedef struct packed {
        logic [SIZE_W-1:0] bottom_mid_y;
        logic [SIZE_W-1:0] bottom_mid_x;
        logic [SIZE_W-1:0] top_mid_y;
        logic [SIZE_W-1:0] top_mid_x;
        logic [SIZE_W-1:0] right_corner_y;
        logic [SIZE_W-1:0] right_corner_x;
        logic [SIZE_W-1:0] left_corner_y;
        logic [SIZE_W-1:0] left_corner_x;
        logic              bottom_found;
        logic              top_found;
    } t_result;

    // coord * size / GRID_SIZE, truncated, saturated to the output range
    function automatic logic [SIZE_W-1:0] f_scale(logic [COORD_W-1:0] coord,
                                                  logic [SIZE_W-1:0] size);
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] quot;
        prod = PROD_W'(coord) * PROD_W'(size);
        quot = prod >> GRID_SHIFT;
        if (quot > PROD_W'(OUT_MAX)) begin
            return OUT_MAX;
        end
        return quot[SIZE_W-1:0];
    endfunction

endpackage

// ===== sv/cfpf_tracker.sv =====
// Input register and running extremes: least and greatest polar angle,
// top and bottom vertical crossings. Depends on cfpf_pkg.
module cfpf_tracker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfpf_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  cfpf_pkg::t_point  i_point,
    input  logic              i_last,
    output logic              o_snap_valid,
    input  logic              i_snap_ready,
    output cfpf_pkg::t_snap   o_snap
);

    function automatic logic f_angle_less(cfpf_pkg::t_point a, cfpf_pkg::t_point b,
                                          logic [cfpf_pkg::COORD_W-1:0] cx,
                                          logic [cfpf_pkg::COORD_W-1:0] cy);
        logic signed [9:0]  ax;
        logic signed [9:0]  ay;
        logic signed [9:0]  bx;
        logic signed [9:0]  by;
        logic               ha;
        logic               hb;
        logic signed [19:0] cr;
        ax = $signed({2'b00, a.x}) - $signed({2'b00, cx});
        ay = $signed({2'b00, a.y}) - $signed({2'b00, cy});
        bx = $signed({2'b00, b.x}) - $signed({2'b00, cx});
        by = $signed({2'b00, b.y}) - $signed({2'b00, cy});
        if (ax == 10'sd0 && ay == 10'sd0) begin
            ax = 10'sd1;
        end
        if (bx == 10'sd0 && by == 10'sd0) begin
            bx = 10'sd1;
        end
        ha = !((ay > 10'sd0) || (ay == 10'sd0 && ax > 10'sd0));
        hb = !((by > 10'sd0) || (by == 10'sd0 && bx > 10'sd0));
        cr = ax * by - ay * bx;
        if (ha != hb) begin
            return hb;
        end
        return cr > 20'sd0;
    endfunction

    logic             r_in_valid;
    cfpf_pkg::t_point r_in_point;
    logic             r_in_last;

    cfpf_pkg::t_point r_min, n_min;
    cfpf_pkg::t_point r_max, n_max;
    cfpf_pkg::t_point r_top, n_top;
    cfpf_pkg::t_point r_bot, n_bot;
    logic             r_seen;
    logic             r_top_seen, n_top_seen;
    logic             r_bot_seen, n_bot_seen;

    logic             advance;

    assign advance = r_in_valid && (!r_in_last || i_snap_ready);
    assign o_ready = !r_in_valid || advance;

    always_comb begin
        n_min      = r_min;
        n_max      = r_max;
        n_top      = r_top;
        n_bot      = r_bot;
        n_top_seen = r_top_seen;
        n_bot_seen = r_bot_seen;
        if (!r_seen) begin
            n_min = r_in_point;
            n_max = r_in_point;
        end else begin
            if (f_angle_less(r_max, r_in_point, i_cfg.angle_cx, i_cfg.angle_cy)) begin
                n_max = r_in_point;
            end
            if (f_angle_less(r_in_point, r_min, i_cfg.angle_cx, i_cfg.angle_cy)) begin
                n_min = r_in_point;
            end
        end
        if (r_in_point.x == i_cfg.vert_cx) begin
            if (r_in_point.y <= i_cfg.vert_cy) begin
                n_top      = r_in_point;
                n_top_seen = 1'b1;
            end else begin
                n_bot      = r_in_point;
                n_bot_seen = 1'b1;
            end
        end
    end

    assign o_snap_valid        = r_in_valid && r_in_last;
    assign o_snap.left         = n_min;
    assign o_snap.right        = n_max;
    assign o_snap.top          = n_top;
    assign o_snap.bottom       = n_bot;
    assign o_snap.top_found    = n_top_seen;
    assign o_snap.bottom_found = n_bot_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_point <= i_point;
            r_in_last  <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_min      <= '0;
            r_max      <= '0;
            r_top      <= '0;
            r_bot      <= '0;
            r_seen     <= 1'b0;
            r_top_seen <= 1'b0;
            r_bot_seen <= 1'b0;
        end else if (advance) begin
            r_min      <= n_min;
            r_max      <= n_max;
            r_top      <= n_top;
            r_bot      <= n_bot;
            r_seen     <= 1'b1;
            r_top_seen <= n_top_seen;
            r_bot_seen <= n_bot_seen;
        end
    end

endmodule

// ===== sv/cfpf_scaler.sv =====
// Snapshot register and result register: scales the four found points
// to image size. Depends on cfpf_pkg.
module cfpf_scaler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfpf_pkg::t_cfg    i_cfg,
    input  logic              i_snap_valid,
    output logic              o_snap_ready,
    input  cfpf_pkg::t_snap   i_snap,
    output logic              o_valid,
    input  logic              i_ready,
    output cfpf_pkg::t_result o_result
);

    logic              r_snap_valid;
    cfpf_pkg::t_snap   r_snap;
    logic              r_out_valid;
    cfpf_pkg::t_result r_out, n_out;
    logic              out_ready;

    assign out_ready    = !r_out_valid || i_ready;
    assign o_snap_ready = !r_snap_valid || out_ready;

    always_comb begin
        n_out.left_corner_x  = cfpf_pkg::f_scale(r_snap.left.x,   i_cfg.width);
        n_out.left_corner_y  = cfpf_pkg::f_scale(r_snap.left.y,   i_cfg.height);
        n_out.right_corner_x = cfpf_pkg::f_scale(r_snap.right.x,  i_cfg.width);
        n_out.right_corner_y = cfpf_pkg::f_scale(r_snap.right.y,  i_cfg.height);
        n_out.top_mid_x      = cfpf_pkg::f_scale(r_snap.top.x,    i_cfg.width);
        n_out.top_mid_y      = cfpf_pkg::f_scale(r_snap.top.y,    i_cfg.height);
        n_out.bottom_mid_x   = cfpf_pkg::f_scale(r_snap.bottom.x, i_cfg.width);
        n_out.bottom_mid_y   = cfpf_pkg::f_scale(r_snap.bottom.y, i_cfg.height);
        n_out.top_found      = r_snap.top_found;
        n_out.bottom_found   = r_snap.bottom_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_snap_ready) begin
                r_snap_valid <= i_snap_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_snap_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid && o_snap_ready) begin
            r_snap <= i_snap;
        end
        if (r_snap_valid && out_ready) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== sv/contour_feature_point_finder_core.sv =====
// Top level of the contour feature point finder: configuration registers,
// tracker and scaler. Depends on cfpf_pkg, cfpf_tracker and cfpf_scaler.
//
// Usage: contour points enter on the slave stream, one per request, x in
// tdata[7:0] and y in tdata[15:8]; tlast marks the final point of a contour.
// A request is taken at every cycle in which tvalid and tready are high; the
// block takes one point per cycle unless a stalled receiver drops tready.
// Only the final point gives a result: the least- and greatest-angle points
// and the top and bottom vertical crossings, scaled to image size, on the
// master stream, with the found flags in tuser. The final point passes
// through the input, snapshot and output registers to o_m_tvalid; the next
// contour starts with the following point, with no gap.
// Registers are written through i_cfg_we, i_cfg_addr and i_cfg_wdata, by the
// user only while the block is idle; the block does not enforce it. Reset clears
// the pipeline and tracked points, sets the centres to 0 and both image sizes to 1.
// When the receiver stalls, the result holds in the output register and one
// more in the snapshot register; points that are not final keep flowing, and
// tready drops only when a final point finds both registers full.
module contour_feature_point_finder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cfpf_pkg::ADDR_W-1:0]         i_cfg_addr,
    input  logic [cfpf_pkg::SIZE_W-1:0]         i_cfg_wdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [15:0]                         i_s_tdata,  // point_x, point_y
    input  logic                                i_s_tlast,  // last_point
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // left_corner_x, left_corner_y, right_corner_x, right_corner_y,
    // top_mid_x, top_mid_y, bottom_mid_x, bottom_mid_y (14 bits each)
    output logic [111:0]                        o_m_tdata,
    output logic [1:0]                          o_m_tuser   // top_found, bottom_found
);

    cfpf_pkg::t_cfg    r_cfg;
    cfpf_pkg::t_point  in_point;
    cfpf_pkg::t_snap   snap;
    cfpf_pkg::t_result result;
    logic              snap_valid;
    logic              snap_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_cx <= '0;
            r_cfg.angle_cy <= '0;
            r_cfg.vert_cx  <= '0;
            r_cfg.vert_cy  <= '0;
            r_cfg.width    <= cfpf_pkg::SIZE_W'(1);
            r_cfg.height   <= cfpf_pkg::SIZE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cfpf_pkg::REG_ANGLE_CX: r_cfg.angle_cx <= i_cfg_wdata[cfpf_pkg::COORD_W-1:0];
                cfpf_pkg::REG_ANGLE_CY: r_cfg.angle_cy <= i_cfg_wdata[cfpf_pkg::COORD_W-1:0];
                cfpf_pkg::REG_VERT_CX:  r_cfg.vert_cx  <= i_cfg_wdata[cfpf_pkg::COORD_W-1:0];
                cfpf_pkg::REG_VERT_CY:  r_cfg.vert_cy  <= i_cfg_wdata[cfpf_pkg::COORD_W-1:0];
                cfpf_pkg::REG_WIDTH:    r_cfg.width    <= i_cfg_wdata;
                cfpf_pkg::REG_HEIGHT:   r_cfg.height   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign in_point.x = i_s_tdata[7:0];
    assign in_point.y = i_s_tdata[15:8];

    cfpf_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_point      (in_point),
        .i_last       (i_s_tlast),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready),
        .o_snap       (snap)
    );

    cfpf_scaler u_scaler (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_snap       (snap),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_result     (result)
    );

    assign o_m_tdata = {result.bottom_mid_y, result.bottom_mid_x,
                        result.top_mid_y, result.top_mid_x,
                        result.right_corner_y, result.right_corner_x,
                        result.left_corner_y, result.left_corner_x};
    assign o_m_tuser = {result.bottom_found, result.top_found};

`ifndef NO_ASSERTIONS
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("slave side stalled with an empty result register");

    a_top_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata[83:56] == 28'd0))
        else $error("top crossing fields set without a top crossing");

    a_bottom_missing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[1]) |-> (o_m_tdata[111:84] == 28'd0))
        else $error("bottom crossing fields set without a bottom crossing");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled result changed or dropped");
`endif

endmodule

// ===== dv/contour_feature_point_finder_core_tb.sv =====
// Self-checking bench for contour_feature_point_finder_core: streams contours of
// grid points, predicts corner and crossing points per contour, checks each result.
// Depends on cfpf_pkg and the core RTL only.
module contour_feature_point_finder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] x;
        logic [7:0] y;
        logic       last;
    } t_contour_point;

    typedef struct {
        logic [13:0] coord [8];
        logic        top_found;
        logic        bottom_found;
    } t_feature_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [2:0]   i_cfg_addr;
    logic [13:0]  i_cfg_wdata;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [15:0]  i_s_tdata;   // point_x, point_y
    logic         i_s_tlast;   // last_point
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [111:0] o_m_tdata;   // left x/y, right x/y, top x/y, bottom x/y
    logic [1:0]   o_m_tuser;   // top_found, bottom_found

    contour_feature_point_finder_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    // register mirror
    logic [7:0]  ang_cx, ang_cy, vert_cx, vert_cy;
    logic [13:0] img_w, img_h;

    // tracked contour state
    cfpf_pkg::t_point least_pt, greatest_pt, top_pt, bottom_pt;
    bit     any_seen, top_seen, bottom_seen;

    t_contour_point  point_queue [$];
    t_feature_result expected_features [$];

    string coord_name [8] = '{"left_corner_x", "left_corner_y", "right_corner_x",
                              "right_corner_y", "top_mid_x", "top_mid_y",
                              "bottom_mid_x", "bottom_mid_y"};

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_rx;
    int error_count;
    int points_sent;
    int contours_checked;
    int top_hits;
    int bottom_hits;
    int settings_used;

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit angle_before(cfpf_pkg::t_point a, cfpf_pkg::t_point b);
        int ax, ay, bx, by;
        bit ha, hb;
        ax = int'(a.x) - int'(ang_cx);
        ay = int'(a.y) - int'(ang_cy);
        bx = int'(b.x) - int'(ang_cx);
        by = int'(b.y) - int'(ang_cy);
        if (ax == 0 && ay == 0) begin
            ax = 1;
        end
        if (bx == 0 && by == 0) begin
            bx = 1;
        end
        ha = !(ay > 0 || (ay == 0 && ax > 0));
        hb = !(by > 0 || (by == 0 && bx > 0));
        if (ha != hb) begin
            return ha < hb;
        end
        return (ax * by - ay * bx) > 0;
    endfunction

    function automatic logic [13:0] to_image(logic [7:0] c, logic [13:0] sz);
        int unsigned q;
        q = (32'(c) * 32'(sz)) / 256;
        return (q > 16383) ? 14'd16383 : q[13:0];
    endfunction

    task automatic clear_contour();
        least_pt = '0;
        greatest_pt = '0;
        top_pt = '0;
        bottom_pt = '0;
        any_seen = 0;
        top_seen = 0;
        bottom_seen = 0;
    endtask

    task automatic track_point(input t_contour_point cp);
        cfpf_pkg::t_point p;
        t_feature_result r;
        p.x = cp.x;
        p.y = cp.y;
        if (!any_seen) begin
            least_pt = p;
            greatest_pt = p;
            any_seen = 1;
        end else begin
            if (angle_before(greatest_pt, p)) begin
                greatest_pt = p;
            end
            if (angle_before(p, least_pt)) begin
                least_pt = p;
            end
        end
        if (cp.x == vert_cx) begin
            if (cp.y <= vert_cy) begin
                top_pt = p;
                top_seen = 1;
            end else begin
                bottom_pt = p;
                bottom_seen = 1;
            end
        end
        if (cp.last) begin
            r.coord[0] = to_image(least_pt.x, img_w);
            r.coord[1] = to_image(least_pt.y, img_h);
            r.coord[2] = to_image(greatest_pt.x, img_w);
            r.coord[3] = to_image(greatest_pt.y, img_h);
            r.coord[4] = top_seen ? to_image(top_pt.x, img_w) : 14'd0;
            r.coord[5] = top_seen ? to_image(top_pt.y, img_h) : 14'd0;
            r.coord[6] = bottom_seen ? to_image(bottom_pt.x, img_w) : 14'd0;
            r.coord[7] = bottom_seen ? to_image(bottom_pt.y, img_h) : 14'd0;
            r.top_found = top_seen;
            r.bottom_found = bottom_seen;
            expected_features.insert(expected_features.size(), r);
            clear_contour();
        end
    endtask

    // point source
    always @(posedge i_clk) begin
        t_contour_point cur;
        bit offer;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                cur = point_queue.pop_front();
                track_point(cur);
                points_sent++;
            end
            if (!i_s_tvalid || o_s_tready) begin
                offer = point_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
                i_s_tvalid <= offer;
                if (offer) begin
                    i_s_tdata <= {point_queue[0].y, point_queue[0].x};
                    i_s_tlast <= point_queue[0].last;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_feature_result want;
        logic [13:0] got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_features.size() == 0) begin
                    flag_error($sformatf("unexpected result tdata=%h tuser=%b",
                                         o_m_tdata, o_m_tuser));
                end else begin
                    want = expected_features.pop_front();
                    contours_checked++;
                    top_hits += int'(want.top_found);
                    bottom_hits += int'(want.bottom_found);
                    for (int i = 0; i < 8; i++) begin
                        got = o_m_tdata[14*i +: 14];
                        if (got !== want.coord[i]) begin
                            flag_error($sformatf("contour %0d %s: got %0d, want %0d",
                                                 contours_checked, coord_name[i], got,
                                                 want.coord[i]));
                        end
                    end
                    if (o_m_tuser[0] !== want.top_found) begin
                        flag_error($sformatf("contour %0d top_found: got %b, want %b",
                                             contours_checked, o_m_tuser[0], want.top_found));
                    end
                    if (o_m_tuser[1] !== want.bottom_found) begin
                        flag_error($sformatf("contour %0d bottom_found: got %b, want %b",
                                             contours_checked, o_m_tuser[1],
                                             want.bottom_found));
                    end
                end
            end
            i_m_tready <= !hold_rx && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input cfpf_pkg::t_reg_idx idx, input logic [13:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic apply_setting(input logic [7:0] acx, acy, vcx, vcy,
                                 input logic [13:0] w, h);
        write_reg(cfpf_pkg::REG_ANGLE_CX, 14'(acx));
        write_reg(cfpf_pkg::REG_ANGLE_CY, 14'(acy));
        write_reg(cfpf_pkg::REG_VERT_CX, 14'(vcx));
        write_reg(cfpf_pkg::REG_VERT_CY, 14'(vcy));
        write_reg(cfpf_pkg::REG_WIDTH, w);
        write_reg(cfpf_pkg::REG_HEIGHT, h);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ang_cx = acx;
        ang_cy = acy;
        vert_cx = vcx;
        vert_cy = vcy;
        img_w = w;
        img_h = h;
        settings_used++;
    endtask

    task automatic queue_point(input int x, y, input bit last);
        t_contour_point cp;
        cp.x = 8'(x);
        cp.y = 8'(y);
        cp.last = last;
        point_queue.insert(point_queue.size(), cp);
    endtask

    function automatic int clip8(int v);
        return (v < 0) ? 0 : (v > 255) ? 255 : v;
    endfunction

    task automatic queue_random_contour(input int len);
        int x, y, px, py;
        px = $urandom_range(0, 255);
        py = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                4: x = int'(vert_cx);
                5: begin
                    x = int'(vert_cx);
                    y = clip8(int'(vert_cy) + int'($urandom_range(0, 2)) - 1);
                end
                6: begin
                    x = int'(ang_cx);
                    y = int'(ang_cy);
                end
                7: begin
                    if ($urandom_range(0, 1)) begin
                        y = int'(ang_cy);
                    end else begin
                        x = int'(ang_cx);
                    end
                end
                8: begin
                    x = px;
                    y = py;
                end
                9: begin
                    x = clip8(int'(ang_cx) + int'($urandom_range(0, 4)) - 2);
                    y = clip8(int'(ang_cy) + int'($urandom_range(0, 4)) - 2);
                end
                default: ;
            endcase
            queue_point(x, y, i == len - 1);
            px = x;
            py = y;
        end
    endtask

    task automatic wait_drained();
        while (point_queue.size() != 0 || expected_features.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    initial begin
        #2_000_000;
        $display("contour_feature_point_finder_core_tb failed");
        $finish;
    end

    initial begin
        int queued;
        int len;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_wdata = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        hold_rx = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ang_cx = '0;
        ang_cy = '0;
        vert_cx = '0;
        vert_cy = '0;
        img_w = 14'd1;
        img_h = 14'd1;
        clear_contour();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: point on the centre, then the grid corners
        queue_point(0, 0, 1);
        queue_point(255, 255, 0);
        queue_point(0, 0, 0);
        queue_point(0, 255, 0);
        queue_point(255, 0, 1);
        wait_drained();

        apply_setting(8'd128, 8'd128, 8'd128, 8'd128, 14'd16383, 14'd16383);
        queue_point(128, 128, 0);
        queue_point(255, 128, 0);
        queue_point(128, 255, 0);
        queue_point(0, 128, 0);
        queue_point(128, 0, 0);
        queue_point(255, 255, 0);
        queue_point(0, 0, 0);
        queue_point(255, 0, 0);
        queue_point(0, 255, 0);
        queue_point(128, 200, 0);
        queue_point(128, 100, 0);
        queue_point(128, 128, 1);
        // equal angles keep the earlier point; no crossings here
        queue_point(130, 130, 0);
        queue_point(140, 140, 0);
        queue_point(10, 10, 1);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle_pct <= 13;
                    recv_idle_pct <= 49;
                end
                1: begin
                    send_idle_pct <= 49;
                    recv_idle_pct <= 13;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            case (ph)
                0: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 14'($urandom_range(1, 16383)),
                                 14'($urandom_range(1, 16383)));
                1: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 14'd16383, 14'd16383);
                2: apply_setting(8'd0, 8'd0, 8'd0, 8'd0, 14'd0, 14'd0);
                3: apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 14'($urandom_range(0, 16383)),
                                 14'($urandom_range(0, 16383)));
                4: apply_setting(8'd0, 8'd255, 8'd255, 8'd0, 14'd1, 14'd16383);
                default: apply_setting(8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)),
                                       14'($urandom_range(1, 16383)),
                                       14'($urandom_range(1, 16383)));
            endcase
            if (ph == 5) begin
                // hold the sink off so results back up and the source stalls
                @(posedge i_clk);
                hold_rx <= 1;
                for (int i = 0; i < 40; i++) begin
                    queue_random_contour($urandom_range(1, 3));
                end
                repeat (400) @(posedge i_clk);
                hold_rx <= 0;
            end
            queued = 0;
            while (queued < 330) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(1, 12);
                queue_random_contour(len);
                queued += len;
            end
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d points in %0d checked contours over %0d register settings;",
                 points_sent, contours_checked, settings_used);
        $display("top crossings found in %0d results, bottom crossings in %0d.",
                 top_hits, bottom_hits);
        if (error_count == 0) begin
            $display("contour_feature_point_finder_core_tb passed");
        end else begin
            $display("contour_feature_point_finder_core_tb failed");
        end
        $finish;
    end

endmodule
